// ----- hdl/ilst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared constants, codes and controller/datapath types for the indexed list.
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // read address select
    localparam logic [1:0] RD_PTR = 2'd0;
    localparam logic [1:0] RD_M1  = 2'd1;
    localparam logic [1:0] RD_P1  = 2'd2;

    typedef struct packed {
        logic       load;      // latch the accepted item
        logic       check;     // record status, set up pointer
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       shift;     // write the read data back one slot over, next cycle
        logic       ptr_dec;
        logic       ptr_inc;
        logic       put;       // write the new value at the position
        logic       cnt_dec;
        logic       clr;
        logic       grab;      // capture removed entry from read data
        logic       hit;       // record find position
        logic       out_load;
    } ilst_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ok;
        logic            ptr_gt_pos;
        logic            del_more;
        logic            find_more;
        logic            match;
        logic            out_free;
    } ilst_stat_t;

endpackage

// ----- hdl/ilst_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_req_if / ilst_rsp_if
// Valid/ready channels carrying list requests and list results.
// ----------------------------------------------------------------------------
interface ilst_req_if
    import ilst_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         search_limit;

    modport source (output valid, output operation, output position, output value,
                    output search_limit, input ready);
    modport sink   (input valid, input operation, input position, input value,
                    input search_limit, output ready);
endinterface

interface ilst_rsp_if
    import ilst_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [CNT_W-1:0]  found_position;
    logic [CNT_W-1:0]         list_length;

    modport source (output valid, output status, output removed_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input found_position, input list_length, output ready);
endinterface

// ----- hdl/indexed_list_insert_delete.sv -----
`timescale 1ns / 1ps
// One item at a time: the next item is taken in the cycle after the result is
// loaded, since every shift or compare step goes through the single read port of
// the entry RAM.
// Reset clears the length, the controller and the result valid; the entry RAM is
// not cleared, and no entry at or beyond the length is ever read.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values with insert, delete, clear and find.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete
    import ilst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ilst_req_if.sink    req,
    ilst_rsp_if.source  rsp
);

    ilst_cmd_t  cmd;
    ilst_stat_t stat;

    ilst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ilst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .operation      (req.operation),
        .position       (req.position),
        .value          (req.value),
        .search_limit   (req.search_limit),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .status         (rsp.status),
        .removed_value  (rsp.removed_value),
        .found_position (rsp.found_position),
        .list_length    (rsp.list_length)
    );

endmodule

// ----- hdl/ilst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ilst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/ilst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_dp
// List datapath: request registers, length, shift pointer, entry RAM and
// the result output register.
// ----------------------------------------------------------------------------
module ilst_dp
    import ilst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [OP_W-1:0]          operation,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  logic [CNT_W-1:0]         search_limit,
    input  ilst_cmd_t                cmd,
    output ilst_stat_t               stat,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] removed_value,
    output logic signed [CNT_W-1:0]  found_position,
    output logic [CNT_W-1:0]         list_length
);

    logic [OP_W-1:0]   op_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] removed_reg;
    logic [CNT_W-1:0]  found_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_removed_reg;
    logic [CNT_W-1:0]  out_found_reg;
    logic [CNT_W-1:0]  out_length_reg;

    logic [STAT_W-1:0] status_calc;
    logic [CNT_W-1:0]  find_n;
    logic [CNT_W-1:0]  ptr_p1;
    logic [CNT_W-1:0]  ptr_m1;
    logic [CNT_W-1:0]  rd_ptr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_free;

    assign ptr_p1 = ptr_reg + CNT_W'(1);
    assign ptr_m1 = ptr_reg - CNT_W'(1);
    assign find_n = (lim_reg < count_reg) ? lim_reg : count_reg;
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        status_calc = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                if (pos_reg > count_reg)
                begin
                    status_calc = ST_RANGE;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_calc = ST_FULL;
                end
            end
            OP_DELETE:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_calc = ST_RANGE;
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_M1:   rd_ptr = ptr_m1;
            RD_P1:   rd_ptr = ptr_p1;
            default: rd_ptr = ptr_reg;
        endcase
    end

    // a shift read lands in the next cycle and is written back from the read port
    assign ram_we    = pend_reg || cmd.put;
    assign ram_waddr = pend_reg ? pend_addr_reg : pos_reg[ADDR_W-1:0];
    assign ram_wdata = pend_reg ? ram_rdata : val_reg;

    ilst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_ptr[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.check)
        begin
            case (op_reg)
                OP_INSERT: ptr_next = count_reg;
                OP_DELETE: ptr_next = pos_reg;
                default:   ptr_next = '0;
            endcase
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_p1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= cmd.shift;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            pos_reg     <= position;
            val_reg     <= $unsigned(value);
            lim_reg     <= search_limit;
            removed_reg <= '0;
            found_reg   <= '1;
        end
        if (cmd.check)
        begin
            status_reg <= status_calc;
        end
        if (cmd.shift)
        begin
            pend_addr_reg <= ptr_reg[ADDR_W-1:0];
        end
        if (cmd.grab)
        begin
            removed_reg <= ram_rdata;
        end
        if (cmd.hit)
        begin
            found_reg <= ptr_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_removed_reg <= removed_reg;
            out_found_reg   <= found_reg;
            out_length_reg  <= count_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.ok         = (status_calc == ST_OK);
    assign stat.ptr_gt_pos = (ptr_reg > pos_reg);
    assign stat.del_more   = (ptr_p1 < count_reg);
    assign stat.find_more  = (ptr_reg < find_n);
    assign stat.match      = (ram_rdata == val_reg);
    assign stat.out_free   = out_free;

    assign rsp_valid      = rsp_valid_reg;
    assign status         = out_status_reg;
    assign removed_value  = $signed(out_removed_reg);
    assign found_position = $signed(out_found_reg);
    assign list_length    = out_length_reg;

`ifndef NO_ASSERTIONS
    a_wport_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !cmd.put)
        else $error("shift write back collides with value write");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

// ----- hdl/ilst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_ctrl
// Request sequencer: checks the item, steps the shift or search loop one
// entry at a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module ilst_ctrl
    import ilst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ilst_stat_t stat,
    output ilst_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_INS_SHIFT = 4'd2;
    localparam logic [3:0] S_INS_PUT   = 4'd3;
    localparam logic [3:0] S_DEL_FETCH = 4'd4;
    localparam logic [3:0] S_DEL_GRAB  = 4'd5;
    localparam logic [3:0] S_DEL_SHIFT = 4'd6;
    localparam logic [3:0] S_FIND_RD   = 4'd7;
    localparam logic [3:0] S_FIND_CMP  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_PTR;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (!stat.ok)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (stat.op)
                        OP_INSERT: state_next = S_INS_SHIFT;
                        OP_DELETE: state_next = S_DEL_FETCH;
                        OP_FIND:   state_next = S_FIND_RD;
                        default:
                        begin
                            cmd.clr    = 1'b1;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                if (stat.ptr_gt_pos)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_M1;
                    cmd.shift   = 1'b1;
                    cmd.ptr_dec = 1'b1;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_DEL_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DEL_GRAB;
            end
            S_DEL_GRAB:
            begin
                cmd.grab   = 1'b1;
                state_next = S_DEL_SHIFT;
            end
            S_DEL_SHIFT:
            begin
                if (stat.del_more)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_P1;
                    cmd.shift   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FIND_RD:
            begin
                if (stat.find_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FIND_CMP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_FIND_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_CHECK))
        else $error("accepted item not checked next cycle");

    a_put_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> (state_reg == S_FINISH))
        else $error("insert did not complete after value write");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE) && req_valid)
        else $error("request latched outside idle");
`endif

endmodule

// ----- tb/ilst_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_result_checker
// Watches the request and result channels of the indexed list, keeps its own
// copy of the list, and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module ilst_result_checker
    import ilst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ilst_req_if  req,
    ilst_rsp_if  rsp,
    output int   mismatch_count,
    output int   results_pending
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [CNT_W-1:0]  found_position;
        logic [CNT_W-1:0]         list_length;
    } list_result_t;

    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    logic [CNT_W-1:0]         list_len;
    list_result_t             pending_results [$];

    // Applies one request to the local list copy and returns its result.
    function automatic list_result_t apply_list_request(
        input logic [OP_W-1:0]          op,
        input logic [CNT_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input logic [CNT_W-1:0]         lim
    );
        list_result_t res;
        int           scan_len;
        bit           hit;
        res.status         = ST_OK;
        res.removed_value  = '0;
        res.found_position = '1;
        hit                = 1'b0;
        case (op)
            OP_INSERT:
            begin
                // position is checked before fullness
                if (pos > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = val;
                    list_len       = list_len + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (pos >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.removed_value = list_vals[pos];
                    for (int i = pos; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len = list_len - 1'b1;
                end
            end
            OP_CLEAR:
                list_len = '0;
            default:
            begin
                scan_len = (lim < list_len) ? lim : list_len;
                for (int i = 0; i < scan_len && !hit; i++)
                begin
                    if (list_vals[i] == val)
                    begin
                        res.found_position = CNT_W'(i);
                        hit                = 1'b1;
                    end
                end
            end
        endcase
        res.list_length = list_len;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            list_len = '0;
            pending_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                pending_results.push_back(apply_list_request(req.operation, req.position,
                                                             req.value, req.search_limit));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.removed_value !== want.removed_value)
                    begin
                        $error("removed_value: expected %0d, got %0d",
                               $signed(want.removed_value), $signed(rsp.removed_value));
                        mismatch_count++;
                    end
                    if (rsp.found_position !== want.found_position)
                    begin
                        $error("found_position: expected %0d, got %0d",
                               $signed(want.found_position), $signed(rsp.found_position));
                        mismatch_count++;
                    end
                    if (rsp.list_length !== want.list_length)
                    begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, rsp.list_length);
                        mismatch_count++;
                    end
                end
            end
        end
        results_pending <= pending_results.size();
    end

endmodule

// ----- tb/indexed_list_insert_delete_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_test
// Drives directed and random list requests with random gaps and result
// stalls; the result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_test
    import ilst_pkg::*;
;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 150;

    typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIX} list_trend_t;

    logic clk = 1'b0;
    logic rst_n;

    ilst_req_if req ();
    ilst_rsp_if rsp ();

    int  mismatch_count;
    int  results_pending;
    int  shadow_len;
    bit  quiet;
    int  idle_cycles;
    logic signed [DATA_W-1:0] value_pool [8];

    indexed_list_insert_delete DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ilst_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small value pool so that finds hit and duplicates occur.
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [CNT_W-1:0] pick_position(input bit for_insert);
        int top_pos;
        int r;
        top_pos = for_insert ? shadow_len : shadow_len - 1;
        r       = $urandom_range(0, 99);
        if (r < 10 || top_pos < 0)
            return CNT_W'($urandom_range(0, 127));
        if (r < 25)
            return '0;
        if (r < 40)
            return CNT_W'(top_pos);
        return CNT_W'($urandom_range(0, top_pos));
    endfunction

    function automatic logic [CNT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 30)
            return CNT_W'($urandom_range(0, 127));
        return CNT_W'($urandom_range(0, shadow_len));
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(input list_trend_t trend);
        int r;
        r = $urandom_range(0, 99);
        case (trend)
            TREND_GROW:
                return (r < 75) ? OP_INSERT : (r < 85) ? OP_DELETE : OP_FIND;
            TREND_SHRINK:
                return (r < 20) ? OP_INSERT : (r < 70) ? OP_DELETE :
                       (r < 98) ? OP_FIND : OP_CLEAR;
            default:
                return (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE :
                       (r < 96) ? OP_FIND : OP_CLEAR;
        endcase
    endfunction

    // Holds the item until accepted; tracks the list length to aim positions.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                             input logic [DATA_W-1:0] val, input logic [CNT_W-1:0] lim);
        int gap;
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.position     <= pos;
        req.value        <= val;
        req.search_limit <= lim;
        do
            @(posedge clk);
        while (!req.ready);
        case (op)
            OP_INSERT: if (pos <= shadow_len && shadow_len < CAPACITY) shadow_len++;
            OP_DELETE: if (pos < shadow_len) shadow_len--;
            OP_CLEAR:  shadow_len = 0;
            default:   ;
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    task automatic send_random(input list_trend_t trend);
        logic [OP_W-1:0] op;
        op = pick_operation(trend);
        send_item(op, pick_position(op == OP_INSERT), pick_value(), pick_limit());
    endtask

    // result side back-pressure
    initial
    begin : rsp_stall
        int stall;
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no handshake for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int          sent;
        int          phase_len;
        list_trend_t trend;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.operation    <= OP_INSERT;
        req.position     <= '0;
        req.value        <= '0;
        req.search_limit <= '0;
        shadow_len        = 0;
        quiet             = 1'b0;
        value_pool[0]     = 32'sh8000_0000;
        value_pool[1]     = 32'sh7FFF_FFFF;
        value_pool[2]     = '0;
        value_pool[3]     = -1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        send_item(OP_FIND,   7'd0,   32'h0000_0000, 7'd127);
        send_item(OP_DELETE, 7'd0,   32'h0000_0000, 7'd0);
        send_item(OP_INSERT, 7'd1,   32'h1234_5678, 7'd0);
        send_item(OP_CLEAR,  7'd0,   32'h0000_0000, 7'd0);
        // extremes, insert at head, middle and end
        send_item(OP_INSERT, 7'd0,   32'h8000_0000, 7'd0);
        send_item(OP_INSERT, 7'd1,   32'h7FFF_FFFF, 7'd0);
        send_item(OP_INSERT, 7'd0,   32'hFFFF_FFFF, 7'd0);
        send_item(OP_INSERT, 7'd1,   32'h0000_0000, 7'd0);
        // list: -1, 0, min, max
        send_item(OP_FIND,   7'd0,   32'h8000_0000, 7'd127);
        send_item(OP_FIND,   7'd0,   32'h7FFF_FFFF, 7'd3);
        send_item(OP_FIND,   7'd0,   32'h7FFF_FFFF, 7'd4);
        send_item(OP_FIND,   7'd0,   32'hFFFF_FFFF, 7'd0);
        // out of range positions
        send_item(OP_INSERT, 7'd127, 32'h5A5A_5A5A, 7'd127);
        send_item(OP_DELETE, 7'd4,   32'h0000_0000, 7'd0);
        send_item(OP_DELETE, 7'd127, 32'h0000_0000, 7'd0);
        // delete tail, then head
        send_item(OP_DELETE, 7'd3,   32'h0000_0000, 7'd0);
        send_item(OP_DELETE, 7'd0,   32'h0000_0000, 7'd0);
        send_item(OP_FIND,   7'd0,   32'h0000_0000, 7'd1);
        // duplicate value, first match wins
        send_item(OP_INSERT, 7'd2,   32'h0000_0000, 7'd0);
        send_item(OP_FIND,   7'd0,   32'h0000_0000, 7'd127);
        send_item(OP_CLEAR,  7'd0,   32'h0000_0000, 7'd0);
        // stale entries past the length must not be seen
        send_item(OP_FIND,   7'd0,   32'h8000_0000, 7'd64);
        drain_results();

        // first phase fills the list to capacity and pushes against it
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0)
            begin
                trend     = TREND_GROW;
                phase_len = 160;
            end
            else
            begin
                trend     = list_trend_t'($urandom_range(0, 2));
                phase_len = $urandom_range(20, 150);
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len; k++)
                send_random(trend);
            sent += phase_len;
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        quiet = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- indexed_list_insert_delete.f -----
hdl/ilst_pkg.sv
hdl/ilst_if.sv
hdl/ilst_ram.sv
hdl/ilst_dp.sv
hdl/ilst_ctrl.sv
hdl/indexed_list_insert_delete.sv
tb/ilst_result_checker.sv
tb/indexed_list_insert_delete_test.sv
